// File: hw/rtl/bfgl_pkg.sv
// Shared types, codes and helpers for the bitmap font glyph layout block.
// No dependencies; bfgl_front, bfgl_back and the top level import this package.
`timescale 1ns / 1ps

package bfgl_pkg;

  // Default glyph table depth
  localparam int GLYPH_COUNT_DEF = 65536;

  // Input command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CHAR  = 2'd2;

  // Character code that breaks the line
  localparam logic [15:0] CODE_NEWLINE = 16'd10;

  // Configuration register indexes
  localparam logic [1:0] REG_LINE_HEIGHT = 2'd0;
  localparam logic [1:0] REG_BASELINE    = 2'd1;
  localparam logic [1:0] REG_TEX_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_TINT        = 2'd3;

  // Operations handed from front to back
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_NEWLINE = 2'd1;
  localparam logic [1:0] OP_CHAR    = 2'd2;

  // One glyph table entry (tex_y and offsets are two's complement)
  typedef struct packed {
    logic [15:0] tex_x;
    logic [16:0] tex_y;
    logic [3:0]  page;
    logic [12:0] w;
    logic [12:0] h;
    logic [11:0] ox;
    logic [11:0] oy;
    logic [13:0] adv;
  } glyph_entry_t;

  localparam int ENTRY_W = $bits(glyph_entry_t);

  // Word in the queue between front and back
  typedef struct packed {
    logic [1:0]   op;
    logic [19:0]  cx;
    logic [19:0]  cy;
    glyph_entry_t glyph;
  } mid_word_t;

  localparam int MID_W = $bits(mid_word_t);

  // One result word
  typedef struct packed {
    logic [19:0] sprite_x;
    logic [19:0] sprite_y;
    logic [15:0] tex_x;
    logic [16:0] tex_y;
    logic [12:0] sprite_width;
    logic [12:0] sprite_height;
    logic [3:0]  texture_page;
    logic [31:0] tint;
  } sprite_t;

  localparam int SPRITE_W = $bits(sprite_t);

  // Configuration values seen by the back end
  typedef struct packed {
    logic [15:0] line_height;
    logic [15:0] baseline;
    logic [31:0] tint;
  } back_cfg_t;

  // Saturate a 22 bit signed value to the signed 20 bit range
  function automatic logic [19:0] sat_s20(input logic signed [21:0] v);
    logic [19:0] r;
    if (v > 22'sd524287) begin
      r = 20'h7FFFF;
    end else if (v < -22'sd524288) begin
      r = 20'h80000;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

  // Saturate a 22 bit signed value to the signed 17 bit range
  function automatic logic [16:0] sat_s17(input logic signed [21:0] v);
    logic [16:0] r;
    if (v > 22'sd65535) begin
      r = 17'h0FFFF;
    end else if (v < -22'sd65536) begin
      r = 17'h10000;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/bfgl_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bfgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, output holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/bfgl_fifo.sv
// Small register FIFO used between front and back and at the result side.
// No dependencies.
`timescale 1ns / 1ps

module bfgl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // pointer and count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// File: hw/rtl/bfgl_front.sv
// Front end: accepts input words, runs the table clearing pass, writes glyph
// loads into the table and reads entries for characters. Uses bfgl_pkg, bfgl_ram.
`timescale 1ns / 1ps

module bfgl_front #(
  parameter int GLYPH_COUNT = bfgl_pkg::GLYPH_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_command,
  input  logic [15:0]         in_char_code,
  input  logic [19:0]         in_coord_x,
  input  logic [19:0]         in_coord_y,
  input  logic [12:0]         in_glyph_width,
  input  logic [12:0]         in_glyph_height,
  input  logic [11:0]         in_offset_x,
  input  logic [11:0]         in_offset_y,
  input  logic [13:0]         in_advance,
  input  logic [3:0]          in_page,
  input  logic [15:0]         texture_height,
  output logic                mid_push,
  output bfgl_pkg::mid_word_t mid_wdata,
  input  logic                mid_full
);

  import bfgl_pkg::*;

  localparam int AW = $clog2(GLYPH_COUNT);

  logic          accept;
  logic          code_ok;
  logic          s1_go;
  logic          s1_v_r, s1_v_nxt;
  logic [1:0]    s1_op_r, op_cls;
  logic          op_keep;
  logic [19:0]   s1_cx_r, s1_cy_r;
  logic          clr_busy_r, clr_busy_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  glyph_entry_t  load_entry;
  logic signed [21:0] flip;

  assign in_full = clr_busy_r || (s1_v_r && mid_full);
  assign accept  = in_push && !in_full;
  assign code_ok = ({1'b0, in_char_code} < 17'(GLYPH_COUNT));
  assign s1_go   = s1_v_r && !mid_full;

  // classify the incoming word
  always_comb begin
    op_cls  = OP_START;
    op_keep = 1'b0;
    case (in_command)
      CMD_START: begin
        op_cls  = OP_START;
        op_keep = 1'b1;
      end
      CMD_CHAR: begin
        if (in_char_code == CODE_NEWLINE) begin
          op_cls  = OP_NEWLINE;
          op_keep = 1'b1;
        end else begin
          op_cls  = OP_CHAR;
          op_keep = code_ok;
        end
      end
      default: begin
        op_keep = 1'b0;
      end
    endcase
  end

  // table entry for a load: clamp atlas x, flip row to bottom origin
  assign flip = $signed({6'b0, texture_height}) - 22'($signed(in_coord_y))
                - $signed({9'b0, in_glyph_height});

  always_comb begin
    if (in_coord_x[19]) begin
      load_entry.tex_x = 16'h0000;
    end else if (in_coord_x[18:16] != 3'b000) begin
      load_entry.tex_x = 16'hFFFF;
    end else begin
      load_entry.tex_x = in_coord_x[15:0];
    end
    load_entry.tex_y = sat_s17(flip);
    load_entry.page  = in_page;
    load_entry.w     = in_glyph_width;
    load_entry.h     = in_glyph_height;
    load_entry.ox    = in_offset_x;
    load_entry.oy    = in_offset_y;
    load_entry.adv   = in_advance;
  end

  // clearing pass after reset, one entry a cycle
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(GLYPH_COUNT - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  // table write: clearing pass or a load
  assign ram_we    = clr_busy_r || (accept && in_command == CMD_LOAD && code_ok);
  assign ram_waddr = clr_busy_r ? clr_idx_r : in_char_code[AW-1:0];
  assign ram_wdata = clr_busy_r ? '0 : load_entry;

  bfgl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(GLYPH_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(in_char_code[AW-1:0]),
    .rdata(ram_rdata)
  );

  // stage 1 waits for the table read
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = op_keep;
    end else if (s1_go) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r <= op_cls;
      s1_cx_r <= in_coord_x;
      s1_cy_r <= in_coord_y;
    end
  end

  assign mid_push        = s1_go;
  assign mid_wdata.op    = s1_op_r;
  assign mid_wdata.cx    = s1_cx_r;
  assign mid_wdata.cy    = s1_cy_r;
  assign mid_wdata.glyph = glyph_entry_t'(ram_rdata);

endmodule

// File: hw/rtl/bfgl_back.sv
// Back end: keeps the pen, handles start and line break, builds sprites.
// Uses bfgl_pkg.
`timescale 1ns / 1ps

module bfgl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bfgl_pkg::back_cfg_t cfg,
  input  logic                mid_empty,
  input  bfgl_pkg::mid_word_t mid_rdata,
  output logic                mid_pop,
  input  logic                res_full,
  output logic                res_push,
  output bfgl_pkg::sprite_t   res_wdata
);

  import bfgl_pkg::*;

  logic        go;
  logic [19:0] pen_x_r, pen_x_nxt;
  logic [19:0] pen_y_r, pen_y_nxt;
  logic [19:0] lsx_r, lsx_nxt;
  logic        emit;
  logic signed [21:0] sx, sy, px_adv, py_nl;
  glyph_entry_t g;

  assign g       = mid_rdata.glyph;
  assign go      = !mid_empty && !res_full;
  assign mid_pop = go;

  // pen and sprite arithmetic
  assign sx = 22'($signed(pen_x_r)) + $signed({10'b0, g.w[12:1]})
              + 22'($signed(g.ox));
  assign sy = 22'($signed(pen_y_r)) + $signed({6'b0, cfg.baseline})
              - $signed({10'b0, g.h[12:1]}) - 22'($signed(g.oy));
  assign px_adv = 22'($signed(pen_x_r)) + $signed({8'b0, g.adv});
  assign py_nl  = 22'($signed(pen_y_r)) - $signed({6'b0, cfg.line_height});
  assign emit   = (g.w != '0) && (g.h != '0);

  always_comb begin
    pen_x_nxt = pen_x_r;
    pen_y_nxt = pen_y_r;
    lsx_nxt   = lsx_r;
    res_push  = 1'b0;
    if (go) begin
      case (mid_rdata.op)
        OP_START: begin
          pen_x_nxt = mid_rdata.cx;
          pen_y_nxt = mid_rdata.cy;
          lsx_nxt   = mid_rdata.cx;
        end
        OP_NEWLINE: begin
          pen_x_nxt = lsx_r;
          pen_y_nxt = sat_s20(py_nl);
        end
        OP_CHAR: begin
          res_push  = emit;
          pen_x_nxt = sat_s20(px_adv);
        end
        default: begin
          res_push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= '0;
      pen_y_r <= '0;
      lsx_r   <= '0;
    end else begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
      lsx_r   <= lsx_nxt;
    end
  end

  // result word
  assign res_wdata.sprite_x      = sat_s20(sx);
  assign res_wdata.sprite_y      = sat_s20(sy);
  assign res_wdata.tex_x         = g.tex_x;
  assign res_wdata.tex_y         = g.tex_y;
  assign res_wdata.sprite_width  = g.w;
  assign res_wdata.sprite_height = g.h;
  assign res_wdata.texture_page  = g.page;
  assign res_wdata.tint          = cfg.tint;

endmodule

// File: hw/rtl/bitmap_font_glyph_layout.sv
// Top level of the bitmap font glyph layout block: config registers, front,
// queue, back and result queue. Uses bfgl_pkg, bfgl_front, bfgl_fifo, bfgl_back.
`timescale 1ns / 1ps

// Usage
//   Input words are pushed with in_push while in_full is low: load (writes one
//   glyph table entry), start (sets pen and line-start x) and character.
//   Sprite words come out as a queue: while out_empty is low the oldest sprite
//   is on the out_ ports, and out_pop takes it.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index at once.
// Throughput: one input word per cycle, sustained, as long as sprites are
//   popped; the glyph table read port and the pen arithmetic in the back end
//   each handle one word a cycle.
// Path: a character's sprite reaches the out_ ports through the table read
//   register, the front/back queue and the back end into the result queue.
// Reset: rst_n clears pen, queues and registers, then a clearing pass zeroes
//   the glyph table (GLYPH_COUNT entries, 65536 by default), one entry a cycle;
//   in_full stays high until it ends. Config writes are taken throughout.
// Stall: when out_pop stays low the result queue fills, the back end stops,
//   the front/back queue fills and in_full rises; nothing is lost.
module bitmap_font_glyph_layout #(
  parameter int GLYPH_COUNT = bfgl_pkg::GLYPH_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic [1:0]         in_command,
  input  logic [15:0]        in_char_code,
  input  logic signed [19:0] in_coord_x,
  input  logic signed [19:0] in_coord_y,
  input  logic [12:0]        in_glyph_width,
  input  logic [12:0]        in_glyph_height,
  input  logic signed [11:0] in_offset_x,
  input  logic signed [11:0] in_offset_y,
  input  logic [13:0]        in_advance,
  input  logic [3:0]         in_page,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [19:0] out_sprite_x,
  output logic signed [19:0] out_sprite_y,
  output logic [15:0]        out_tex_x,
  output logic signed [16:0] out_tex_y,
  output logic [12:0]        out_sprite_width,
  output logic [12:0]        out_sprite_height,
  output logic [3:0]         out_texture_page,
  output logic [31:0]        out_tint
);

  import bfgl_pkg::*;

  localparam int MID_DEPTH = 4;
  localparam int RES_DEPTH = 2;

  logic [15:0] line_height_r, baseline_r, tex_height_r;
  logic [31:0] tint_r;
  back_cfg_t   back_cfg;

  logic      mid_push, mid_full, mid_pop, mid_empty;
  mid_word_t mid_wdata, mid_rdata;
  logic [MID_W-1:0] mid_rbits;

  logic      res_push, res_full;
  sprite_t   res_wdata, res_rdata;
  logic [SPRITE_W-1:0] res_rbits;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_height_r <= '0;
      baseline_r    <= '0;
      tex_height_r  <= '0;
      tint_r        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_HEIGHT: line_height_r <= cfg_wdata[15:0];
        REG_BASELINE:    baseline_r    <= cfg_wdata[15:0];
        REG_TEX_HEIGHT:  tex_height_r  <= cfg_wdata[15:0];
        REG_TINT:        tint_r        <= cfg_wdata;
        default: begin
          tint_r <= tint_r;
        end
      endcase
    end
  end

  assign back_cfg.line_height = line_height_r;
  assign back_cfg.baseline    = baseline_r;
  assign back_cfg.tint        = tint_r;

  // front end
  bfgl_front #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_glyph_width (in_glyph_width),
    .in_glyph_height(in_glyph_height),
    .in_offset_x    (in_offset_x),
    .in_offset_y    (in_offset_y),
    .in_advance     (in_advance),
    .in_page        (in_page),
    .texture_height (tex_height_r),
    .mid_push       (mid_push),
    .mid_wdata      (mid_wdata),
    .mid_full       (mid_full)
  );

  // queue between front and back
  bfgl_fifo #(
    .WIDTH(MID_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (mid_push),
    .wdata(mid_wdata),
    .full (mid_full),
    .pop  (mid_pop),
    .rdata(mid_rbits),
    .empty(mid_empty)
  );

  assign mid_rdata = mid_word_t'(mid_rbits);

  // back end
  bfgl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (back_cfg),
    .mid_empty(mid_empty),
    .mid_rdata(mid_rdata),
    .mid_pop  (mid_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_wdata(res_wdata)
  );

  // result queue
  bfgl_fifo #(
    .WIDTH(SPRITE_W),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_wdata),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_rbits),
    .empty(out_empty)
  );

  assign res_rdata         = sprite_t'(res_rbits);
  assign out_sprite_x      = res_rdata.sprite_x;
  assign out_sprite_y      = res_rdata.sprite_y;
  assign out_tex_x         = res_rdata.tex_x;
  assign out_tex_y         = res_rdata.tex_y;
  assign out_sprite_width  = res_rdata.sprite_width;
  assign out_sprite_height = res_rdata.sprite_height;
  assign out_texture_page  = res_rdata.texture_page;
  assign out_tint          = res_rdata.tint;

endmodule
